[rtl/integer_to_ascii_formatter_unit_macros.svh]
// Assertion macros shared by the checker of the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define I2A_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define I2A_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/i2a_pkg.sv]
// Package: constants, codes, types and character helpers of the integer to ASCII formatter.
package i2a_pkg;

  localparam int MAX_WIDTH_DEF = 62;
  localparam int PTR_DIGITS    = 8;

  localparam int VAL_W   = 64;
  localparam int CMD_W   = 3;
  localparam int MW_W    = 6;
  localparam int CHAR_W  = 7;
  localparam int DEC_DIGITS = 20;
  localparam int HEX_DIGITS = 16;
  localparam int BCD_W   = 4 * DEC_DIGITS;
  localparam int DCNT_W  = $clog2(DEC_DIGITS + 1);
  localparam int STEP_W  = $clog2(VAL_W);
  localparam int LEN_W   = MW_W + 1;

  localparam logic [CMD_W-1:0] CMD_SDEC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UDEC = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HEXL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HEXU = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PTR  = 3'd4;

  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
  localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;
  localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

  // Map one digit to its ASCII code, upper or lower case letters for hex.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UA : CH_LA;
    if (nib < 4'd10) begin
      digit_char = CH_ZERO + {3'b000, nib};
    end else begin
      digit_char = base + {3'b000, nib - 4'd10};
    end
  endfunction

endpackage

[rtl/i2a_if.sv]
// Stream interfaces: number requests in, formatted characters out.
interface i2a_num_if
  import i2a_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [VAL_W-1:0]  value;
  logic              is_wide;
  logic [MW_W-1:0]   min_width;
  logic              zero_pad;

  modport source (output valid, cmd, value, is_wide, min_width, zero_pad, input ready);
  modport sink   (input valid, cmd, value, is_wide, min_width, zero_pad, output ready);
endinterface

interface i2a_char_if
  import i2a_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last;

  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface

[rtl/i2a_bcd_conv.sv]
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module i2a_bcd_conv
  import i2a_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] bin_in,
  output conv_stat_t       stat,
  output logic [BCD_W-1:0] bcd
);

  logic [VAL_W-1:0]  bin;
  logic [BCD_W-1:0]  bcd_adj;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(VAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= bin_in;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[VAL_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[VAL_W-1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[rtl/integer_to_ascii_formatter_unit.sv]
// Flow: a hex or pointer number goes straight to leading-zero removal once taken; a decimal
// one first passes through the bit-serial BCD converter. Leading zero digits are then
// dropped, one per cycle, up to 15 for hex and 19 for decimal, and the padding is planned.
// A new number is taken only after the last character of the previous one is issued; the
// sequencer emits one character per cycle while the sink is ready and holds when it stalls.
// Reset (synchronous, rst high) clears the sequencer, the converter control and output valid.
module integer_to_ascii_formatter_unit
  import i2a_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  i2a_num_if.sink    num,
  i2a_char_if.source text
);

  localparam int CW = $clog2(MAX_WIDTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CONV  = 4'd1;
  localparam logic [3:0] S_NORM  = 4'd2;
  localparam logic [3:0] S_PLAN  = 4'd3;
  localparam logic [3:0] S_PFX0  = 4'd4;
  localparam logic [3:0] S_PFX1  = 4'd5;
  localparam logic [3:0] S_LEAD  = 4'd6;
  localparam logic [3:0] S_PAD   = 4'd7;
  localparam logic [3:0] S_TRAIL = 4'd8;
  localparam logic [3:0] S_DIGIT = 4'd9;

  logic [3:0]        state;
  logic [BCD_W-1:0]  digits;
  logic [DCNT_W-1:0] nd;
  logic [MW_W-1:0]   pad;
  logic [MW_W-1:0]   wid;
  logic [CW-1:0]     ecnt;
  logic              neg;
  logic              zpad;
  logic              upper;
  logic              is_ptr;
  logic              o_valid;
  logic [CHAR_W-1:0] o_char;
  logic              o_last;

  logic              accept;
  logic              cmd_ok;
  logic              is_dec;
  logic [VAL_W-1:0]  ext;
  logic              neg_in;
  logic [VAL_W-1:0]  mag;
  logic              conv_start;
  conv_stat_t        conv_stat;
  logic [BCD_W-1:0]  conv_bcd;
  logic [LEN_W-1:0]  total;
  logic [MW_W-1:0]   pad_calc;
  logic              slot_free;
  logic              emit;
  logic              fin;
  logic              num_end;
  logic [CHAR_W-1:0] ch;
  logic [3:0]        nxt;

  // First state after any prefix: sign, padding or digits.
  function automatic logic [3:0] entry_state(input logic zp, input logic ng, input logic pnz);
    if (zp) begin
      entry_state = ng ? S_LEAD : (pnz ? S_PAD : S_DIGIT);
    end else begin
      entry_state = pnz ? S_PAD : (ng ? S_TRAIL : S_DIGIT);
    end
  endfunction

  assign accept = num.valid && num.ready;
  assign num.ready = (state == S_IDLE);
  assign cmd_ok = (num.cmd == CMD_SDEC) || (num.cmd == CMD_UDEC) || (num.cmd == CMD_HEXL) ||
                  (num.cmd == CMD_HEXU) || (num.cmd == CMD_PTR);
  assign is_dec = (num.cmd == CMD_SDEC) || (num.cmd == CMD_UDEC);

  always_comb begin
    if (num.is_wide) begin
      ext = num.value;
    end else if (num.cmd == CMD_SDEC && num.value[31]) begin
      ext = {32'hFFFF_FFFF, num.value[31:0]};
    end else begin
      ext = {32'h0000_0000, num.value[31:0]};
    end
    neg_in = (num.cmd == CMD_SDEC) && ext[VAL_W-1];
    mag = neg_in ? (VAL_W'(0) - ext) : ext;
  end

  assign conv_start = accept && is_dec;

  i2a_bcd_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .bin_in (mag),
    .stat   (conv_stat),
    .bcd    (conv_bcd)
  );

  always_comb begin
    total = LEN_W'(nd) + LEN_W'(neg);
    if (LEN_W'(wid) > total) begin
      pad_calc = MW_W'(LEN_W'(wid) - total);
    end else begin
      pad_calc = '0;
    end
  end

  assign slot_free = !o_valid || text.ready;

  always_comb begin
    emit    = 1'b1;
    num_end = 1'b0;
    ch      = CH_SPACE;
    nxt     = S_IDLE;
    case (state)
      S_PFX0: begin
        ch  = CH_ZERO;
        nxt = S_PFX1;
      end
      S_PFX1: begin
        ch  = CH_X;
        nxt = entry_state(zpad, neg, pad != '0);
      end
      S_LEAD: begin
        ch  = CH_MINUS;
        nxt = (pad != '0) ? S_PAD : S_DIGIT;
      end
      S_PAD: begin
        ch = zpad ? CH_ZERO : CH_SPACE;
        if (pad == MW_W'(1)) begin
          nxt = (!zpad && neg) ? S_TRAIL : S_DIGIT;
        end else begin
          nxt = S_PAD;
        end
      end
      S_TRAIL: begin
        ch  = CH_MINUS;
        nxt = S_DIGIT;
      end
      S_DIGIT: begin
        ch      = digit_char(digits[BCD_W-1 -: 4], upper);
        nxt     = S_DIGIT;
        num_end = (nd == DCNT_W'(1));
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    // Cut the text at the field limit.
    fin = num_end || (ecnt == CW'(MAX_WIDTH - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && cmd_ok) begin
            state <= is_dec ? S_CONV : S_NORM;
          end
        end
        S_CONV: begin
          if (conv_stat.done) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (digits[BCD_W-1 -: 4] == 4'd0 && nd != DCNT_W'(1)) begin
            state <= S_NORM;
          end else begin
            state <= S_PLAN;
          end
        end
        S_PLAN: begin
          state <= is_ptr ? S_PFX0 : entry_state(zpad, neg, pad_calc != '0);
        end
        default: begin
          if (emit && slot_free) begin
            state <= fin ? S_IDLE : nxt;
          end
        end
      endcase
      if (emit && slot_free) begin
        o_valid <= 1'b1;
      end else if (text.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg    <= neg_in;
      upper  <= (num.cmd == CMD_HEXU);
      is_ptr <= (num.cmd == CMD_PTR);
      ecnt   <= '0;
      digits <= {mag, {(BCD_W - VAL_W){1'b0}}};
      nd     <= DCNT_W'(HEX_DIGITS);
      if (num.cmd == CMD_PTR) begin
        wid  <= MW_W'(PTR_DIGITS);
        zpad <= 1'b1;
      end else begin
        wid  <= (num.min_width > MW_W'(MAX_WIDTH)) ? MW_W'(MAX_WIDTH) : num.min_width;
        zpad <= num.zero_pad;
      end
    end else if (state == S_CONV) begin
      digits <= conv_bcd;
      nd     <= DCNT_W'(DEC_DIGITS);
    end else if (state == S_NORM) begin
      // Drop a leading zero digit, keep at least one.
      if (digits[BCD_W-1 -: 4] == 4'd0 && nd != DCNT_W'(1)) begin
        digits <= {digits[BCD_W-5:0], 4'd0};
        nd     <= nd - 1'b1;
      end
    end else if (state == S_PLAN) begin
      pad <= pad_calc;
    end else if (emit && slot_free) begin
      o_char <= ch;
      o_last <= fin;
      ecnt   <= ecnt + 1'b1;
      if (state == S_PAD) begin
        pad <= pad - 1'b1;
      end
      if (state == S_DIGIT) begin
        digits <= {digits[BCD_W-5:0], 4'd0};
        nd     <= nd - 1'b1;
      end
    end
  end

  assign text.valid    = o_valid;
  assign text.char_out = o_char;
  assign text.last     = o_last;

endmodule

[rtl/i2a_checker.sv]
// Port-level checker for the integer to ASCII formatter and its bind.
`include "integer_to_ascii_formatter_unit_macros.svh"

module i2a_checker
  import i2a_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CMD_W-1:0]  in_cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] char_out,
  input logic              last
);

  // Hold a stalled output transaction.
  `I2A_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_out) && $stable(last), "stalled output changed")

  // Block new numbers right after a known command is taken; unknown ones are dropped.
  `I2A_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready && in_cmd <= CMD_PTR, !in_ready, "input ready after accept")

  // Keep input closed while a number is still being sent.
  `I2A_ASSERT_SAME(a_busy_mid_number, out_valid && !last, !in_ready, "input ready mid number")

  // Emit only space, sign, digits, letters and 'x'.
  `I2A_ASSERT_SAME(a_char_range, out_valid, char_out >= CH_SPACE && char_out <= CH_X, "bad character")

endmodule

bind integer_to_ascii_formatter_unit i2a_checker u_i2a_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (num.valid),
  .in_ready  (num.ready),
  .in_cmd    (num.cmd),
  .out_valid (text.valid),
  .out_ready (text.ready),
  .char_out  (text.char_out),
  .last      (text.last)
);
